### hw/rtl/ibsd_pkg.sv
// Package for the IL2P byte scrambler / descrambler.
// Holds the result types, LFSR seeds and the bytewise LFSR functions.
// No dependencies.
`default_nettype none

package ibsd_pkg;

	localparam logic [8:0] SEED_TX = 9'h00f;
	localparam logic [8:0] SEED_RX = 9'h1f0;
	localparam int unsigned FLUSH_BITS = 5;

	// Mode codes of the direction register
	localparam logic DIR_SCRAMBLE   = 1'b0;
	localparam logic DIR_DESCRAMBLE = 1'b1;

	typedef struct packed {
		logic [7:0] result_byte;
		logic       last_out;
	} ibsd_res_t;

	// Results of one processed item, r0 goes out first
	typedef struct packed {
		logic [1:0] count;
		ibsd_res_t  r0;
		ibsd_res_t  r1;
	} ibsd_push_t;

	typedef struct packed {
		logic [8:0] sr;
		logic [7:0] bits;
	} ibsd_step_t;

	// Eight scrambler steps, MSB of the byte first
	function automatic ibsd_step_t scramble_byte(input logic [8:0] sr_in, input logic [7:0] d);
		logic [8:0] s;
		logic [7:0] acc;
		ibsd_step_t r;
		s = sr_in;
		acc = '0;
		for (int i = 7; i >= 0; i--) begin
			acc = {acc[6:0], s[4] ^ s[0]};
			s = {d[i] ^ s[0], s[8:5], s[4] ^ s[0], s[3:1]};
		end
		r.sr = s;
		r.bits = acc;
		return r;
	endfunction

	// Five scrambler steps on zero bits, result in the low bits
	function automatic ibsd_step_t scramble_flush(input logic [8:0] sr_in);
		logic [8:0] s;
		logic [7:0] acc;
		ibsd_step_t r;
		s = sr_in;
		acc = '0;
		for (int i = 0; i < FLUSH_BITS; i++) begin
			acc = {acc[6:0], s[4] ^ s[0]};
			s = {s[0], s[8:5], s[4] ^ s[0], s[3:1]};
		end
		r.sr = s;
		r.bits = acc;
		return r;
	endfunction

	// Eight descrambler steps, MSB of the byte first
	function automatic ibsd_step_t descramble_byte(input logic [8:0] sr_in, input logic [7:0] d);
		logic [8:0] s;
		logic [7:0] acc;
		ibsd_step_t r;
		s = sr_in;
		acc = '0;
		for (int i = 7; i >= 0; i--) begin
			acc = {acc[6:0], d[i] ^ s[0]};
			s = {d[i], s[8:5], s[4] ^ d[i], s[3:1]};
		end
		r.sr = s;
		r.bits = acc;
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ibsd_core.sv
// Scrambler / descrambler state and per-byte result logic.
// Holds direction, LFSR, held bits and block-start flag; uses ibsd_pkg.
`default_nettype none

module ibsd_core
	import ibsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic       cfg_dir,
	input  wire logic [7:0] data_s1,
	input  wire logic       last_s1,
	input  wire logic       process,
	output ibsd_push_t      push
);

	logic       direction_q;
	logic [8:0] sr_q;
	logic [2:0] held_q;
	logic       start_q;

	ibsd_step_t sc;
	ibsd_step_t fl;
	ibsd_step_t ds;
	ibsd_res_t  mid_res;
	ibsd_res_t  fin_res;

	// Bytewise LFSR results
	always_comb begin
		sc = scramble_byte(sr_q, data_s1);
		fl = scramble_flush(sc.sr);
		ds = descramble_byte(sr_q, data_s1);
	end

	// Result selection; count is that of the byte in s1, whether or not it is taken
	always_comb begin
		mid_res.result_byte = {held_q, sc.bits[7:3]};
		mid_res.last_out    = 1'b0;
		fin_res.result_byte = {sc.bits[2:0], fl.bits[4:0]};
		fin_res.last_out    = 1'b1;
		push = '0;
		if (direction_q == DIR_DESCRAMBLE) begin
			push.count          = 2'd1;
			push.r0.result_byte = ds.bits;
			push.r0.last_out    = last_s1;
		end else begin
			push.count = {1'b0, ~start_q} + {1'b0, last_s1};
			if (start_q) begin
				push.r0 = fin_res;
			end else begin
				push.r0 = mid_res;
				push.r1 = fin_res;
			end
		end
	end

	// State update on config write or processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_SCRAMBLE;
			sr_q        <= SEED_TX;
			held_q      <= '0;
			start_q     <= 1'b1;
		end else if (cfg_write) begin
			direction_q <= cfg_dir;
			sr_q        <= (cfg_dir == DIR_DESCRAMBLE) ? SEED_RX : SEED_TX;
			held_q      <= '0;
			start_q     <= 1'b1;
		end else if (process) begin
			if (last_s1) begin
				sr_q    <= (direction_q == DIR_DESCRAMBLE) ? SEED_RX : SEED_TX;
				held_q  <= '0;
				start_q <= 1'b1;
			end else if (direction_q == DIR_DESCRAMBLE) begin
				sr_q <= ds.sr;
			end else begin
				sr_q    <= sc.sr;
				held_q  <= sc.bits[2:0];
				start_q <= 1'b0;
			end
		end
	end

	// A scrambled first byte that is not last never gives a result
	a_first_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(process && direction_q == DIR_SCRAMBLE && start_q && !last_s1) |-> push.count == 2'd0)
		else $error("first byte of a block produced output");

	// Block start flag is set again after the last byte
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(process && last_s1 && !cfg_write) |=> start_q)
		else $error("block start not restored after last byte");

	// Descrambling always gives exactly one result per byte
	a_rx_one: assert property (@(posedge clk) disable iff (!arst_n)
		(direction_q == DIR_DESCRAMBLE) |-> push.count == 2'd1)
		else $error("descrambled byte gave other than one result");

endmodule

`default_nettype wire

### hw/rtl/ibsd_out_fifo.sv
// Two-entry result queue that takes up to two results per cycle.
// Drives the master-side stream; uses ibsd_pkg.
`default_nettype none

module ibsd_out_fifo
	import ibsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ibsd_push_t push,
	output logic [1:0]      free,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast
);

	ibsd_res_t  ent_q [2];
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic       wr0;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = ent_q[rd_ptr_q].result_byte;
	assign m_tlast  = ent_q[rd_ptr_q].last_out;
	// room includes the entry leaving with this cycle's transfer
	assign free     = 2'd2 - cnt_q + {1'b0, pop};
	assign wr0      = rd_ptr_q ^ cnt_q[0];

	// Entry storage, second result goes behind the first
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			ent_q[wr0] <= push.r0;
		end
		if (push.count == 2'd2) begin
			ent_q[~wr0] <= push.r1;
		end
	end

	// Read pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_q ^ pop;
			cnt_q    <= cnt_q + push.count - {1'b0, pop};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count <= free)
		else $error("result queue overflow");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1 && pop && push.count == 2'd0) |=> !m_tvalid)
		else $error("result queue not empty after last transfer");

endmodule

`default_nettype wire

### hw/rtl/il2p_byte_scrambler_descrambler.sv
// IL2P byte scrambler / descrambler, top level.
// Instantiates ibsd_core and ibsd_out_fifo; uses ibsd_pkg.
//
// Usage:
//   s_* : input bytes of a block, MSB first, tlast on the final byte.
//   m_* : result bytes, tlast on the final byte of the block.
//   cfg_*: one-bit direction write (0 scramble, 1 descramble); always ready.
//     A write reloads the mode's seed and starts a new block. Write only
//     while no transfer is in progress.
// Path: a taken byte is registered in s1, processed into the result queue
//   once the queue has room for its results, and offered on m_* from there.
// Throughput: one input byte per cycle while the result queue has room. A
//   scrambled block's first byte gives no result and its last byte gives two;
//   rate is set by the output transfer of one byte a cycle.
// Reset: direction is scramble, LFSR at the transmit seed, queues empty.
// Stall: when m_tready is low the two-entry result queue fills, the input
//   register holds its byte and s_tready drops; nothing is lost.
`default_nettype none

module il2p_byte_scrambler_descrambler
	import ibsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,   // last_in
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] result_byte
	output logic            m_tlast,   // last_out
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [0:0] cfg_data   // [0] direction
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       process;
	logic [1:0] need;
	logic [1:0] core_need;
	logic [1:0] free;
	ibsd_push_t probe;
	ibsd_push_t push;

	assign cfg_ready = 1'b1;

	// Byte in s1 is taken once the queue has room for all its results
	assign core_need = probe.count;
	assign need      = push.count;
	assign process   = valid_s1 && (core_need <= free);
	assign s_tready  = !valid_s1 || process;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Core gives the results of the byte in s1; its state moves only on process or a config write
	ibsd_core u_probe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_dir   (cfg_data[0]),
		.data_s1   (data_s1),
		.last_s1   (last_s1),
		.process   (process),
		.push      (probe)
	);

	always_comb begin
		push = probe;
		if (!process) begin
			push.count = 2'd0;
		end
	end

	ibsd_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_need_match: assert property (@(posedge clk) disable iff (!arst_n)
		process |-> need == core_need)
		else $error("pushed count differs from requested count");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !process) |=> (valid_s1 && $stable(data_s1) && $stable(last_s1)))
		else $error("stalled input register changed");

	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> push.count == 2'd0)
		else $error("results pushed without a registered byte");

endmodule

`default_nettype wire
